// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules.
// Depends on signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define AST_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define AST_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/jpp_pkg.sv -----
// Types and constants for the JSON pretty printer.
// No dependencies; used by the front, queue, back and top modules.
package jpp_pkg;

   localparam int DEPTH_W = 5;
   localparam int SPACE_W = DEPTH_W + 1;
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = 2;
   localparam int Q_CNT_W = 3;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       run_last;
      logic       depth_clipped;
   } rsp_payload_type;

   // One output burst: c0, optional c1, spaces, optional c2.
   typedef struct packed {
      logic [7:0]         c0;
      logic               has_c1;
      logic [7:0]         c1;
      logic [SPACE_W-1:0] spaces;
      logic               has_c2;
      logic [7:0]         c2;
      logic               clipped;
   } cmd_type;

   typedef enum logic [3:0] {
      PH_C0 = 4'b0001,
      PH_C1 = 4'b0010,
      PH_SP = 4'b0100,
      PH_C2 = 4'b1000
   } phase_type;

endpackage

// ----- rtl/jpp_front.sv -----
// Front end: accepts request bytes, tracks string/escape/depth state, classifies
// each byte into a burst command. Depends on jpp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jpp_front #(
   parameter int MAX_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     acc,
   input  jpp_pkg::req_payload_type req,
   output logic                     push,
   output jpp_pkg::cmd_type         cmd
);
   import jpp_pkg::*;

   logic               in_str_ff, in_str_in;
   logic               esc_ff, esc_in;
   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               clip_ff, clip_in;
   logic [7:0]         ch;
   logic               is_ws;

   assign ch    = req.in_char;
   assign is_ws = ch inside {[CH_TAB:CH_CR], CH_SPACE};

   always_comb begin
      in_str_in  = in_str_ff;
      esc_in     = esc_ff;
      depth_in   = depth_ff;
      clip_in    = clip_ff;
      push       = 1'b0;
      cmd.c0     = ch;
      cmd.has_c1 = 1'b0;
      cmd.c1     = CH_NL;
      cmd.spaces = '0;
      cmd.has_c2 = 1'b0;
      cmd.c2     = ch;
      if (acc) begin
         if (in_str_ff) begin
            push = 1'b1;
            if (esc_ff) begin
               esc_in = 1'b0;
            end else if (ch == CH_BSLASH) begin
               esc_in = 1'b1;
            end else if (ch == CH_QUOTE) begin
               in_str_in = 1'b0;
            end
         end else begin
            case (ch)
               CH_QUOTE: begin
                  push      = 1'b1;
                  in_str_in = 1'b1;
                  esc_in    = 1'b0;
               end
               CH_LBRACE, CH_LBRACK: begin
                  push       = 1'b1;
                  cmd.has_c1 = 1'b1;
                  if (depth_ff < DEPTH_W'(MAX_DEPTH)) begin
                     depth_in = depth_ff + 1'b1;
                  end else begin
                     clip_in = 1'b1;
                  end
                  cmd.spaces = {depth_in, 1'b0};
               end
               CH_RBRACE, CH_RBRACK: begin
                  push       = 1'b1;
                  cmd.c0     = CH_NL;
                  cmd.has_c2 = 1'b1;
                  if (depth_ff != '0) begin
                     depth_in = depth_ff - 1'b1;
                  end
                  cmd.spaces = {depth_in, 1'b0};
               end
               CH_COLON: begin
                  push       = 1'b1;
                  cmd.has_c1 = 1'b1;
                  cmd.c1     = CH_SPACE;
               end
               CH_COMMA: begin
                  push       = 1'b1;
                  cmd.has_c1 = 1'b1;
                  cmd.spaces = {depth_ff, 1'b0};
               end
               default: begin
                  push = !is_ws;
               end
            endcase
         end
      end
      cmd.clipped = clip_in;
      // Drop all text state after the final byte.
      if (acc && req.in_last) begin
         in_str_in = 1'b0;
         esc_in    = 1'b0;
         depth_in  = '0;
         clip_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_str_ff <= 1'b0;
         esc_ff    <= 1'b0;
         depth_ff  <= '0;
         clip_ff   <= 1'b0;
      end else begin
         in_str_ff <= in_str_in;
         esc_ff    <= esc_in;
         depth_ff  <= depth_in;
         clip_ff   <= clip_in;
      end
   end

   `AST_IMP(a_depth_bound, 1'b1, depth_ff <= DEPTH_W'(MAX_DEPTH))
   `AST_NXT(a_last_clears, acc && req.in_last, depth_ff == '0 && !in_str_ff && !clip_ff)
   `AST_IMP(a_esc_in_str, esc_ff, in_str_ff)
endmodule

// ----- rtl/jpp_queue.sv -----
// Short command queue between front and back end, held in flip-flops.
// Depends on jpp_pkg and assert_macros.svh.
`include "assert_macros.svh"
module jpp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jpp_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output jpp_pkg::cmd_type head_cmd
);
   import jpp_pkg::*;

   cmd_type            entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ff, wr_in;
   logic [Q_PTR_W-1:0] rd_ff, rd_in;
   logic [Q_CNT_W-1:0] cnt_ff, cnt_in;

   assign full       = cnt_ff == Q_CNT_W'(Q_DEPTH);
   assign head_valid = cnt_ff != '0;
   assign head_cmd   = entry_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + Q_CNT_W'(push) - Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

   `AST_IMP(a_no_overflow, push, !full)
   `AST_IMP(a_no_underflow, pop, head_valid)
endmodule

// ----- rtl/jpp_back.sv -----
// Back end: expands the queue-head command into bytes in the response register,
// one per cycle while it is free or taken. Depends on jpp_pkg, assert_macros.svh.
`include "assert_macros.svh"
module jpp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  jpp_pkg::cmd_type         head_cmd,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output jpp_pkg::rsp_payload_type rsp_payload
);
   import jpp_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [SPACE_W-1:0] sp_cnt_ff, sp_cnt_in;
   logic               vld_ff, vld_in;
   rsp_payload_type    out_ff, out_in;
   logic               load;
   logic               sp_done;

   assign load    = head_valid && (!vld_ff || rsp_ready);
   assign sp_done = sp_cnt_ff == head_cmd.spaces - 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      sp_cnt_in = sp_cnt_ff;
      pop       = 1'b0;
      out_in    = out_ff;
      vld_in    = vld_ff && !rsp_ready;
      if (load) begin
         vld_in               = 1'b1;
         out_in.depth_clipped = head_cmd.clipped;
         out_in.run_last      = 1'b0;
         case (phase_ff)
            PH_C0: begin
               out_in.out_char = head_cmd.c0;
               if (head_cmd.has_c1) begin
                  phase_in = PH_C1;
               end else if (head_cmd.spaces != '0) begin
                  phase_in = PH_SP;
               end else if (head_cmd.has_c2) begin
                  phase_in = PH_C2;
               end else begin
                  out_in.run_last = 1'b1;
               end
            end
            PH_C1: begin
               out_in.out_char = head_cmd.c1;
               if (head_cmd.spaces != '0) begin
                  phase_in = PH_SP;
               end else if (head_cmd.has_c2) begin
                  phase_in = PH_C2;
               end else begin
                  out_in.run_last = 1'b1;
                  phase_in        = PH_C0;
               end
            end
            PH_SP: begin
               out_in.out_char = CH_SPACE;
               sp_cnt_in       = sp_cnt_ff + 1'b1;
               if (sp_done) begin
                  sp_cnt_in = '0;
                  if (head_cmd.has_c2) begin
                     phase_in = PH_C2;
                  end else begin
                     out_in.run_last = 1'b1;
                     phase_in        = PH_C0;
                  end
               end
            end
            PH_C2: begin
               out_in.out_char = head_cmd.c2;
               out_in.run_last = 1'b1;
               phase_in        = PH_C0;
            end
            default: begin
               phase_in = PH_C0;
            end
         endcase
         pop = out_in.run_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_C0;
         sp_cnt_ff <= '0;
         vld_ff    <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         sp_cnt_ff <= sp_cnt_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_valid   = vld_ff;
   assign rsp_payload = out_ff;

   `AST_IMP(a_phase_onehot, 1'b1, $onehot(phase_ff))
   `AST_IMP(a_sp_has_work, phase_ff == PH_SP, head_valid && head_cmd.spaces != '0)
   `AST_NXT(a_pop_marks_last, pop, rsp_valid && rsp_payload.run_last)
endmodule

// ----- rtl/json_pretty_printer_top.sv -----
// JSON pretty printer top level: front end, command queue and back end.
// Depends on jpp_pkg, jpp_front, jpp_queue and jpp_back.
//
// Reindents compact JSON text with two spaces per nesting level. Each request
// carries one input byte and an end-of-text mark; each response carries one
// output byte, a mark on the last byte caused by that request, and a sticky
// flag that nesting went past MAX_DEPTH (1..31) in the current text. The front
// end takes one request per cycle while the four-entry command queue has room;
// whitespace outside strings produces no response. The back end emits exactly
// one response byte per cycle from the command at the queue head while the
// output register is free or being taken. A request produces one byte for most
// bytes, two for a colon, and 2 + 2*depth for a brace, bracket or comma (up to
// 64 at depth 31). The output register holds a response until it is taken; the
// back end loads the next byte at the same edge, so a steady receiver sees one
// byte per cycle, and the queue lets the front keep accepting plain bytes
// during an indentation burst.
module json_pretty_printer_top #(
   parameter int MAX_DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  jpp_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output jpp_pkg::rsp_payload_type rsp_payload
);
   import jpp_pkg::*;

   logic    q_full;
   logic    req_acc;
   logic    cmd_push;
   cmd_type cmd_new;
   logic    head_valid;
   cmd_type head_cmd;
   logic    head_pop;

   // Hold requests off only while the queue is full.
   assign req_ready = !q_full;
   assign req_acc   = req_valid && req_ready;

   // Classify the byte and advance string/depth state.
   jpp_front #(
      .MAX_DEPTH (MAX_DEPTH)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .acc   (req_acc),
      .req   (req_payload),
      .push  (cmd_push),
      .cmd   (cmd_new)
   );

   // Buffer burst commands between the two halves.
   jpp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd_new),
      .full       (q_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Expand each command into response bytes.
   jpp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .pop         (head_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );
endmodule
